// ===== rtl/dcmp_pkg.sv =====
// Shared types and constants for the display command message parser.
package dcmp_pkg;

  localparam int MESSAGE_BYTES = 43;
  localparam int ROW_COUNT     = 6;
  localparam int TEXT_LIMIT    = 40;

  localparam logic [7:0] ROW_MASK = 8'((1 << ROW_COUNT) - 1);

  localparam logic [2:0] EV_CLEAR    = 3'd0;
  localparam logic [2:0] EV_INVERT   = 3'd1;
  localparam logic [2:0] EV_SCROLL   = 3'd2;
  localparam logic [2:0] EV_TRACK    = 3'd3;
  localparam logic [2:0] EV_TEXT_HDR = 3'd4;
  localparam logic [2:0] EV_TEXT_CHR = 3'd5;
  localparam logic [2:0] EV_UNKNOWN  = 3'd6;

  localparam logic [7:0] OP_END       = 8'h00;
  localparam logic [7:0] OP_CLEAR     = 8'h03;
  localparam logic [7:0] OP_INVERT    = 8'h05;
  localparam logic [7:0] OP_SCROLL    = 8'h68;
  localparam logic [7:0] OP_TRACK     = 8'h69;
  localparam logic [7:0] OP_TEXT      = 8'hE0;
  localparam logic [7:0] OP_TEXT_WIDE = 8'hE2;
  localparam logic [7:0] OP_TEXT_HL   = 8'hE3;

  localparam logic [6:0] FIXED_DISPLAY_LEN = 7'd30;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_start;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] row_mask;
    logic [2:0] row_index;
    logic [7:0] pixel_start;
    logic [7:0] pixel_end;
    logic [7:0] enable_value;
    logic       highlighted;
    logic [6:0] text_length;
    logic [6:0] display_length;
    logic [7:0] char_value;
    logic [5:0] position;
    logic [7:0] bad_opcode;
  } out_beat_t;

endpackage

// ===== rtl/dcmp_parser.sv =====
// Parse state and per-byte decode of command messages into events.
module dcmp_parser #(
  parameter int MESSAGE_BYTES = dcmp_pkg::MESSAGE_BYTES,
  parameter int ROW_COUNT     = dcmp_pkg::ROW_COUNT,
  parameter int TEXT_LIMIT    = dcmp_pkg::TEXT_LIMIT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  dcmp_pkg::in_beat_t  beat,
  output logic                res_valid,
  output dcmp_pkg::out_beat_t res
);

  localparam logic [3:0] PH_OPCODE = 4'd0;
  localparam logic [3:0] PH_SKIP   = 4'd1;
  localparam logic [3:0] PH_ARG1   = 4'd2;
  localparam logic [3:0] PH_BAR1   = 4'd3;
  localparam logic [3:0] PH_BAR2   = 4'd4;
  localparam logic [3:0] PH_BAR3   = 4'd5;
  localparam logic [3:0] PH_BAR4   = 4'd6;
  localparam logic [3:0] PH_TROW   = 4'd7;
  localparam logic [3:0] PH_TWHAT  = 4'd8;
  localparam logic [3:0] PH_TLEN   = 4'd9;
  localparam logic [3:0] PH_TENC   = 4'd10;
  localparam logic [3:0] PH_TCHAR  = 4'd11;

  localparam logic [7:0] ROW_MASK = 8'((1 << ROW_COUNT) - 1);

  // Total length of a command that carries nothing we decode; zero if unknown.
  function automatic logic [3:0] skip_length(input logic [7:0] op);
    logic [3:0] len;
    unique case (op)
      8'h3D, 8'h3F, 8'h3B, 8'hFF, 8'h37, 8'h1F, 8'h2F: len = 4'd3;
      8'h02, 8'h04, 8'h13, 8'h1B,
      8'h20, 8'h23, 8'h24, 8'h30:                      len = 4'd2;
      8'h50, 8'h53, 8'h54, 8'h56, 8'h6A, 8'h6B:        len = 4'd5;
      8'h75:                                           len = 4'd7;
      8'h91:                                           len = 4'd10;
      default:                                         len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] lowest_row(input logic [7:0] bits);
    logic [2:0] row;
    row = 3'd0;
    for (int r = ROW_COUNT - 1; r >= 0; r--) begin
      if (bits[r]) row = 3'(r);
    end
    return row;
  endfunction

  logic [5:0] byte_count_r, byte_count_nxt;
  logic [3:0] phase_r, phase_nxt;
  logic [7:0] opcode_r, opcode_nxt;
  logic [3:0] skip_r, skip_nxt;
  logic [7:0] start_r, start_nxt;
  logic [7:0] end_r, end_nxt;
  logic [2:0] row_r, row_nxt;
  logic [6:0] chars_left_r, chars_left_nxt;
  logic [5:0] char_index_r, char_index_nxt;
  logic       done_r, done_nxt;

  logic [5:0] cnt;
  logic [3:0] ph;
  logic       dn;
  logic [7:0] b;
  logic [3:0] skip_len;
  logic [3:0] skip_dec;
  logic [6:0] chars_dec;

  assign b         = beat.data_byte;
  assign skip_len  = skip_length(b);
  assign skip_dec  = skip_r - 4'd1;
  assign chars_dec = chars_left_r - 7'd1;

  always_comb begin
    byte_count_nxt = byte_count_r;
    phase_nxt      = phase_r;
    opcode_nxt     = opcode_r;
    skip_nxt       = skip_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    row_nxt        = row_r;
    chars_left_nxt = chars_left_r;
    char_index_nxt = char_index_r;
    done_nxt       = done_r;
    res_valid      = 1'b0;
    res            = '0;
    cnt = beat.message_start ? 6'd0 : byte_count_r;
    ph  = beat.message_start ? PH_OPCODE : phase_r;
    dn  = beat.message_start ? 1'b0 : done_r;
    if (acc) begin
      byte_count_nxt = cnt;
      phase_nxt      = ph;
      done_nxt       = dn;
      if (!dn) begin
        if (cnt >= 6'(MESSAGE_BYTES)) begin
          done_nxt = 1'b1;
        end else begin
          byte_count_nxt = cnt + 6'd1;
          unique case (ph)
            PH_OPCODE: begin
              opcode_nxt = b;
              if (b == dcmp_pkg::OP_END) begin
                done_nxt = 1'b1;
              end else if (b == dcmp_pkg::OP_CLEAR || b == dcmp_pkg::OP_INVERT) begin
                phase_nxt = PH_ARG1;
              end else if (b == dcmp_pkg::OP_SCROLL || b == dcmp_pkg::OP_TRACK) begin
                phase_nxt = PH_BAR1;
              end else if (b == dcmp_pkg::OP_TEXT || b == dcmp_pkg::OP_TEXT_WIDE ||
                           b == dcmp_pkg::OP_TEXT_HL) begin
                phase_nxt = PH_TROW;
              end else if (skip_len != 4'd0) begin
                skip_nxt  = skip_len - 4'd1;
                phase_nxt = PH_SKIP;
              end else begin
                res.event_kind = dcmp_pkg::EV_UNKNOWN;
                res.position   = cnt;
                res.bad_opcode = b;
                res_valid      = 1'b1;
                done_nxt       = 1'b1;
              end
            end
            PH_SKIP: begin
              skip_nxt = skip_dec;
              if (skip_dec == 4'd0) phase_nxt = PH_OPCODE;
            end
            PH_ARG1: begin
              if (opcode_r == dcmp_pkg::OP_CLEAR) begin
                res.event_kind = dcmp_pkg::EV_CLEAR;
                res.row_mask   = b & ROW_MASK;
              end else begin
                res.event_kind = dcmp_pkg::EV_INVERT;
                res.row_mask   = ~b;
              end
              res_valid = 1'b1;
              phase_nxt = PH_OPCODE;
            end
            PH_BAR1: begin
              if (opcode_r == dcmp_pkg::OP_TRACK) row_nxt = lowest_row(b);
              else start_nxt = b;
              phase_nxt = PH_BAR2;
            end
            PH_BAR2: begin
              if (opcode_r == dcmp_pkg::OP_TRACK) start_nxt = b;
              else end_nxt = b;
              phase_nxt = PH_BAR3;
            end
            PH_BAR3: begin
              if (opcode_r == dcmp_pkg::OP_TRACK) end_nxt = b;
              phase_nxt = PH_BAR4;
            end
            PH_BAR4: begin
              if (opcode_r == dcmp_pkg::OP_TRACK) begin
                res.event_kind = dcmp_pkg::EV_TRACK;
                res.row_index  = row_r;
              end else begin
                res.event_kind = dcmp_pkg::EV_SCROLL;
              end
              res.pixel_start  = start_r;
              res.pixel_end    = end_r;
              res.enable_value = b;
              res_valid        = 1'b1;
              phase_nxt        = PH_OPCODE;
            end
            PH_TROW: begin
              row_nxt   = lowest_row(b);
              phase_nxt = (opcode_r == dcmp_pkg::OP_TEXT_WIDE) ? PH_TWHAT : PH_TLEN;
            end
            PH_TWHAT: phase_nxt = PH_TLEN;
            PH_TLEN: begin
              chars_left_nxt = b[6:0];
              phase_nxt      = PH_TENC;
            end
            PH_TENC: begin
              res.event_kind     = dcmp_pkg::EV_TEXT_HDR;
              res.row_index      = row_r;
              res.highlighted    = (opcode_r == dcmp_pkg::OP_TEXT_HL);
              res.text_length    = chars_left_r;
              res.display_length = (opcode_r == dcmp_pkg::OP_TEXT_WIDE) ?
                                   chars_left_r : dcmp_pkg::FIXED_DISPLAY_LEN;
              res_valid          = 1'b1;
              char_index_nxt     = 6'd0;
              phase_nxt          = (chars_left_r == 7'd0) ? PH_OPCODE : PH_TCHAR;
            end
            PH_TCHAR: begin
              // Consume every declared character; report only up to the limit.
              if (char_index_r < 6'(TEXT_LIMIT)) begin
                res.event_kind = dcmp_pkg::EV_TEXT_CHR;
                res.char_value = b;
                res.position   = char_index_r;
                res_valid      = 1'b1;
                char_index_nxt = char_index_r + 6'd1;
              end
              chars_left_nxt = chars_dec;
              if (chars_dec == 7'd0) phase_nxt = PH_OPCODE;
            end
            default: phase_nxt = PH_OPCODE;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      phase_r      <= PH_OPCODE;
      opcode_r     <= '0;
      skip_r       <= '0;
      start_r      <= '0;
      end_r        <= '0;
      row_r        <= '0;
      chars_left_r <= '0;
      char_index_r <= '0;
      done_r       <= 1'b1;
    end else begin
      byte_count_r <= byte_count_nxt;
      phase_r      <= phase_nxt;
      opcode_r     <= opcode_nxt;
      skip_r       <= skip_nxt;
      start_r      <= start_nxt;
      end_r        <= end_nxt;
      row_r        <= row_nxt;
      chars_left_r <= chars_left_nxt;
      char_index_r <= char_index_nxt;
      done_r       <= done_nxt;
    end
  end

endmodule

// ===== rtl/dcmp_out_buf.sv =====
// Two-entry result register with skid slot between the parser and the output.
module dcmp_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dcmp_pkg::out_beat_t push_beat,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output dcmp_pkg::out_beat_t out_beat
);

  dcmp_pkg::out_beat_t head_r, skid_r;
  logic [1:0]          count_r, count_nxt;
  logic                pop;

  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign out_beat  = head_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Payload: advance the skid slot into the head on pop, park new beats behind.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count_r == 2'd2) begin
        head_r <= skid_r;
        if (push) skid_r <= push_beat;
      end else if (push) begin
        head_r <= push_beat;
      end
    end else if (push) begin
      if (count_r == 2'd0) head_r <= push_beat;
      else skid_r <= push_beat;
    end
  end

endmodule

// ===== rtl/display_command_message_parser.sv =====
// Top level: display command message parser, one byte per beat in, decoded events out.
//
//   port group  dir  handshake           payload
//   in_*        in   in_valid/in_stall   dcmp_pkg::in_beat_t  (data_byte, message_start)
//   out_*       out  out_valid/out_stall dcmp_pkg::out_beat_t (event fields)
//
// One byte is taken per cycle while in_stall is low; its event, if any, is registered.
// The parse state updates in the cycle a byte is taken, so bytes follow back to back.
// Reset (rst_n low, synchronous) leaves the parser idle until a byte with message_start.
// A two-entry result register absorbs one output stall; in_stall rises only when
// both entries hold undelivered events.
module display_command_message_parser #(
  parameter int MESSAGE_BYTES = dcmp_pkg::MESSAGE_BYTES,
  parameter int ROW_COUNT     = dcmp_pkg::ROW_COUNT,
  parameter int TEXT_LIMIT    = dcmp_pkg::TEXT_LIMIT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dcmp_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output dcmp_pkg::out_beat_t out_beat
);

  logic                acc;
  logic                res_valid;
  dcmp_pkg::out_beat_t res;
  logic                full;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  dcmp_parser #(
    .MESSAGE_BYTES (MESSAGE_BYTES),
    .ROW_COUNT     (ROW_COUNT),
    .TEXT_LIMIT    (TEXT_LIMIT)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .beat      (in_beat),
    .res_valid (res_valid),
    .res       (res)
  );

  dcmp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_beat (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the display command message parser: random messages, event checks.
module testbench;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_BYTES  = 1450;
  localparam int CALM_TAIL     = 150;
  localparam int PRESSURE_AT   = 400;
  localparam int PRESSURE_LEN  = 300;
  localparam int DRAIN_CYCLES  = 20;

  localparam logic [7:0] OP_SKIP7     = 8'h75;
  localparam logic [7:0] OP_SKIP10    = 8'h91;
  localparam logic [7:0] OP_UNKNOWN   = 8'h01;
  localparam logic [7:0] OP_SKIP_DIR  = 8'h3D;

  // opcodes skipped along with their arguments, grouped by total command length
  localparam int N_SKIP2 = 8;
  localparam int N_SKIP3 = 7;
  localparam int N_SKIP5 = 6;
  localparam logic [N_SKIP2*8-1:0] SKIP2_OPS =
    {8'h02, 8'h04, 8'h13, 8'h1B, 8'h20, 8'h23, 8'h24, 8'h30};
  localparam logic [N_SKIP3*8-1:0] SKIP3_OPS =
    {8'h3D, 8'h3F, 8'h3B, 8'hFF, 8'h37, 8'h1F, 8'h2F};
  localparam logic [N_SKIP5*8-1:0] SKIP5_OPS =
    {8'h50, 8'h53, 8'h54, 8'h56, 8'h6A, 8'h6B};

  typedef enum logic [3:0] {
    ST_OPCODE, ST_SKIP, ST_ARG1, ST_BAR1, ST_BAR2, ST_BAR3, ST_BAR4,
    ST_TROW, ST_TWHAT, ST_TLEN, ST_TENC, ST_TCHAR
  } parse_state_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  dcmp_pkg::in_beat_t  in_beat = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  dcmp_pkg::out_beat_t out_beat;

  display_command_message_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dcmp_pkg::in_beat_t  byte_queue[$];
  dcmp_pkg::out_beat_t predicted_events[$];
  logic      fresh = 1'b0;
  int        mismatches = 0;
  int        cycle_count = 0;
  int        bytes_taken = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        hold_left = 0;
  logic      pressure_done = 1'b0;
  logic      calm = 1'b0;

  // parser shadow state
  logic [5:0]   byte_cnt = '0;
  parse_state_t state = ST_OPCODE;
  logic [7:0]   cur_op = '0;
  logic [3:0]   skip_left = '0;
  logic [7:0]   bar_start = '0;
  logic [7:0]   bar_end = '0;
  logic [2:0]   row_sel = '0;
  logic [6:0]   chars_remaining = '0;
  logic [5:0]   char_pos = '0;
  logic         msg_over = 1'b1;

  function automatic logic [2:0] lowest_row(input logic [7:0] bits);
    for (int r = 0; r < dcmp_pkg::ROW_COUNT && r < 8; r++)
      if (bits[r]) return 3'(r);
    return 3'd0;
  endfunction

  function automatic int skip_total(input logic [7:0] op);
    for (int i = 0; i < N_SKIP2; i++) if (SKIP2_OPS[i*8 +: 8] == op) return 2;
    for (int i = 0; i < N_SKIP3; i++) if (SKIP3_OPS[i*8 +: 8] == op) return 3;
    for (int i = 0; i < N_SKIP5; i++) if (SKIP5_OPS[i*8 +: 8] == op) return 5;
    if (op == OP_SKIP7) return 7;
    if (op == OP_SKIP10) return 10;
    return 0;
  endfunction

  // Advance the shadow parser by one byte; fires is set when an event results.
  function automatic void decode_byte(input dcmp_pkg::in_beat_t b, output logic fires,
                                      output dcmp_pkg::out_beat_t ev);
    logic [5:0] at;
    logic [7:0] d;
    int         len;
    fires = 1'b0;
    ev = '0;
    d = b.data_byte;
    if (b.message_start) begin
      byte_cnt = '0;
      state = ST_OPCODE;
      msg_over = 1'b0;
    end
    if (msg_over) return;
    if (int'(byte_cnt) >= dcmp_pkg::MESSAGE_BYTES) begin
      msg_over = 1'b1;
      return;
    end
    at = byte_cnt;
    byte_cnt = byte_cnt + 6'd1;
    case (state)
      ST_OPCODE: begin
        cur_op = d;
        len = skip_total(d);
        if (d == dcmp_pkg::OP_END) begin
          msg_over = 1'b1;
        end else if (d == dcmp_pkg::OP_CLEAR || d == dcmp_pkg::OP_INVERT) begin
          state = ST_ARG1;
        end else if (d == dcmp_pkg::OP_SCROLL || d == dcmp_pkg::OP_TRACK) begin
          state = ST_BAR1;
        end else if (d == dcmp_pkg::OP_TEXT || d == dcmp_pkg::OP_TEXT_WIDE ||
                     d == dcmp_pkg::OP_TEXT_HL) begin
          state = ST_TROW;
        end else if (len != 0) begin
          skip_left = 4'(len - 1);
          state = ST_SKIP;
        end else begin
          ev.event_kind = dcmp_pkg::EV_UNKNOWN;
          ev.position = at;
          ev.bad_opcode = d;
          fires = 1'b1;
          msg_over = 1'b1;
        end
      end
      ST_SKIP: begin
        skip_left = skip_left - 4'd1;
        if (skip_left == 4'd0) state = ST_OPCODE;
      end
      ST_ARG1: begin
        if (cur_op == dcmp_pkg::OP_CLEAR) begin
          ev.event_kind = dcmp_pkg::EV_CLEAR;
          ev.row_mask = d & dcmp_pkg::ROW_MASK;
        end else begin
          ev.event_kind = dcmp_pkg::EV_INVERT;
          ev.row_mask = ~d;
        end
        fires = 1'b1;
        state = ST_OPCODE;
      end
      ST_BAR1: begin
        if (cur_op == dcmp_pkg::OP_TRACK) row_sel = lowest_row(d);
        else bar_start = d;
        state = ST_BAR2;
      end
      ST_BAR2: begin
        if (cur_op == dcmp_pkg::OP_TRACK) bar_start = d;
        else bar_end = d;
        state = ST_BAR3;
      end
      ST_BAR3: begin
        if (cur_op == dcmp_pkg::OP_TRACK) bar_end = d;
        state = ST_BAR4;
      end
      ST_BAR4: begin
        if (cur_op == dcmp_pkg::OP_TRACK) begin
          ev.event_kind = dcmp_pkg::EV_TRACK;
          ev.row_index = row_sel;
        end else begin
          ev.event_kind = dcmp_pkg::EV_SCROLL;
        end
        ev.pixel_start = bar_start;
        ev.pixel_end = bar_end;
        ev.enable_value = d;
        fires = 1'b1;
        state = ST_OPCODE;
      end
      ST_TROW: begin
        row_sel = lowest_row(d);
        state = (cur_op == dcmp_pkg::OP_TEXT_WIDE) ? ST_TWHAT : ST_TLEN;
      end
      ST_TWHAT: state = ST_TLEN;
      ST_TLEN: begin
        chars_remaining = d[6:0];
        state = ST_TENC;
      end
      ST_TENC: begin
        ev.event_kind = dcmp_pkg::EV_TEXT_HDR;
        ev.row_index = row_sel;
        ev.highlighted = (cur_op == dcmp_pkg::OP_TEXT_HL);
        ev.text_length = chars_remaining;
        ev.display_length = (cur_op == dcmp_pkg::OP_TEXT_WIDE) ?
                            chars_remaining : dcmp_pkg::FIXED_DISPLAY_LEN;
        fires = 1'b1;
        char_pos = '0;
        state = (chars_remaining == 7'd0) ? ST_OPCODE : ST_TCHAR;
      end
      ST_TCHAR: begin
        // past the text limit the bytes are still consumed, silently
        if (int'(char_pos) < dcmp_pkg::TEXT_LIMIT) begin
          ev.event_kind = dcmp_pkg::EV_TEXT_CHR;
          ev.char_value = d;
          ev.position = char_pos;
          fires = 1'b1;
          char_pos = char_pos + 6'd1;
        end
        chars_remaining = chars_remaining - 7'd1;
        if (chars_remaining == 7'd0) state = ST_OPCODE;
      end
      default: state = ST_OPCODE;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void put(input logic [7:0] d);
    dcmp_pkg::in_beat_t t;
    t.data_byte = d;
    t.message_start = fresh;
    fresh = 1'b0;
    byte_queue.push_back(t);
  endfunction

  function automatic logic [7:0] rand_rows();
    return ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
  endfunction

  function automatic void put_text(input logic [7:0] op, input int n_chars);
    put(op);
    put(rand_rows());
    if (op == dcmp_pkg::OP_TEXT_WIDE) put(8'($urandom));
    put({1'($urandom), 7'(n_chars)});
    put(8'($urandom));
    for (int i = 0; i < n_chars; i++) put(8'($urandom));
  endfunction

  function automatic logic [7:0] pick_skip_op();
    int k;
    k = $urandom_range(0, N_SKIP2 + N_SKIP3 + N_SKIP5 + 1);
    if (k < N_SKIP2) return SKIP2_OPS[k*8 +: 8];
    k -= N_SKIP2;
    if (k < N_SKIP3) return SKIP3_OPS[k*8 +: 8];
    k -= N_SKIP3;
    if (k < N_SKIP5) return SKIP5_OPS[k*8 +: 8];
    return (k == N_SKIP5) ? OP_SKIP7 : OP_SKIP10;
  endfunction

  // One message: mostly well-formed commands with random content, some noise and cut-offs.
  function automatic void build_message();
    int base, target, pick, n, len;
    logic [7:0] op;
    base = byte_queue.size();
    fresh = 1'b1;
    if ($urandom_range(0, 99) < 8) begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        fresh = 1'($urandom);
        put(8'($urandom));
      end
      return;
    end
    target = $urandom_range(8, 50);
    while (byte_queue.size() - base < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        put(dcmp_pkg::OP_CLEAR); put(8'($urandom));
      end else if (pick < 22) begin
        put(dcmp_pkg::OP_INVERT); put(8'($urandom));
      end else if (pick < 34) begin
        put(dcmp_pkg::OP_SCROLL);
        for (int i = 0; i < 4; i++) put(8'($urandom));
      end else if (pick < 46) begin
        put(dcmp_pkg::OP_TRACK); put(rand_rows());
        for (int i = 0; i < 3; i++) put(8'($urandom));
      end else if (pick < 64) begin
        case ($urandom_range(0, 2))
          0: op = dcmp_pkg::OP_TEXT;
          1: op = dcmp_pkg::OP_TEXT_WIDE;
          default: op = dcmp_pkg::OP_TEXT_HL;
        endcase
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 127) : $urandom_range(0, 10);
        put_text(op, n);
      end else if (pick < 80) begin
        op = pick_skip_op();
        len = skip_total(op);
        put(op);
        for (int i = 1; i < len; i++) put(8'($urandom));
      end else if (pick < 84) begin
        // random opcode, mostly unknown: an unknown one ends parsing and trailing bytes must be ignored
        put(8'($urandom_range(6, 8'h2E)));
        for (int i = 0; i < 3; i++) put(8'($urandom));
        break;
      end else if (pick < 90) begin
        // abandon a command halfway; the next message start cuts it off
        put(($urandom_range(0, 1) == 0) ? dcmp_pkg::OP_TRACK : dcmp_pkg::OP_TEXT_WIDE);
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) put(8'($urandom));
        return;
      end else begin
        put(8'($urandom));
        put(8'($urandom));
      end
    end
    if ($urandom_range(0, 1) == 0) put(dcmp_pkg::OP_END);
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) put(8'($urandom));
    end
  endfunction

  initial begin
    // directed: extremes of each command, end and unknown opcodes, restart mid-command
    fresh = 1'b1;
    put(dcmp_pkg::OP_CLEAR); put(8'hFF);
    put(dcmp_pkg::OP_INVERT); put(8'h00);
    put(dcmp_pkg::OP_SCROLL); put(8'h00); put(8'hFF); put(8'h5A); put(8'hAA);
    put(dcmp_pkg::OP_TRACK); put(8'h20); put(8'hFF); put(8'h00); put(8'h80);
    put(dcmp_pkg::OP_END);
    put(8'h7E);
    fresh = 1'b1;
    put(dcmp_pkg::OP_TEXT_HL); put(8'h00); put(8'h80); put(8'h00);
    put(dcmp_pkg::OP_TEXT_WIDE); put(8'h40); put(8'hFF); put(8'h02); put(8'h11);
    put(8'hFF); put(8'h00);
    put(OP_SKIP_DIR); put(8'h03); put(8'h05);
    put(OP_UNKNOWN);
    fresh = 1'b1;
    put(dcmp_pkg::OP_TEXT); put(8'h01);
    fresh = 1'b1;
    put(8'hFE);

    while (byte_queue.size() < RANDOM_BYTES) build_message();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (byte_queue.size() != 0 || in_valid || predicted_events.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // ----------------------------------------------------------------- driving

  always @(posedge clk) begin : drive
    logic                fires;
    dcmp_pkg::out_beat_t ev;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_beat, fires, ev);
        if (fires) predicted_events.push_back(ev);
        bytes_taken <= bytes_taken + 1;
      end
      calm <= (byte_queue.size() < CALM_TAIL);
      // hold a stalled beat; otherwise advance
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_beat <= byte_queue.pop_front();
          if (!calm && cycle_count[8] && $urandom_range(0, 5) == 0)
            gap_left <= $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!pressure_done && bytes_taken >= PRESSURE_AT) begin
      // long hold-off: the result buffer fills and the input must stall
      pressure_done <= 1'b1;
      hold_left <= PRESSURE_LEN;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && cycle_count[9] && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : watch
    dcmp_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_events.size() == 0) begin
        report_mismatch("unexpected event, kind", 8'(out_beat.event_kind), 8'h00);
      end else begin
        want = predicted_events.pop_front();
        check_field("event_kind", 8'(out_beat.event_kind), 8'(want.event_kind));
        check_field("row_mask", out_beat.row_mask, want.row_mask);
        check_field("row_index", 8'(out_beat.row_index), 8'(want.row_index));
        check_field("pixel_start", out_beat.pixel_start, want.pixel_start);
        check_field("pixel_end", out_beat.pixel_end, want.pixel_end);
        check_field("enable_value", out_beat.enable_value, want.enable_value);
        check_field("highlighted", 8'(out_beat.highlighted), 8'(want.highlighted));
        check_field("text_length", 8'(out_beat.text_length), 8'(want.text_length));
        check_field("display_length", 8'(out_beat.display_length),
                    8'(want.display_length));
        check_field("char_value", out_beat.char_value, want.char_value);
        check_field("position", 8'(out_beat.position), 8'(want.position));
        check_field("bad_opcode", out_beat.bad_opcode, want.bad_opcode);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

// ===== files.f =====
rtl/dcmp_pkg.sv
rtl/dcmp_parser.sv
rtl/dcmp_out_buf.sv
rtl/display_command_message_parser.sv
tb/testbench.sv
